// ===== src/lprt_pkg.sv =====
// shared types, constants and helpers for the longest prefix route table
// no dependencies; imported by lprt_match and longest_prefix_route_table
package lprt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;
  localparam int HOP_W       = 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [LEN_W-1:0]  MAX_PREFIX = LEN_W'(ADDR_W);
  localparam logic [ADDR_W-1:0] ALL_ONES   = {ADDR_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] network;
    logic [LEN_W-1:0]  length;
    logic [HOP_W-1:0]  hop;
  } lprt_entry_t;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] length;
    logic [HOP_W-1:0] hop;
  } lprt_best_t;

  localparam int ENTRY_W = $bits(lprt_entry_t);

  // clamp prefix length to the address width
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    return (len > MAX_PREFIX) ? MAX_PREFIX : len;
  endfunction

  // prefix mask, length already saturated
  function automatic logic [ADDR_W-1:0] mask_of(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] sh;
    sh = MAX_PREFIX - len;
    return (len == '0) ? '0 : (ALL_ONES << sh);
  endfunction

endpackage

// ===== src/lprt_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module lprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/lprt_match.sv =====
// shared masked-compare unit: checks one route per cycle while en is high and keeps the best so far
// depends on lprt_pkg
module lprt_match import lprt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              en,
  input  logic [ADDR_W-1:0] dest,
  input  lprt_entry_t       entry,
  output lprt_best_t        best
);

  lprt_best_t       best_r;
  lprt_best_t       best_nxt;
  logic [ADDR_W-1:0] mask;
  logic              match;
  logic              take;

  assign mask  = mask_of(entry.length);
  assign match = ((dest ^ entry.network) & mask) == '0;
  // strictly longer wins, so the earliest route keeps a tie
  assign take  = match && (!best_r.found || (entry.length > best_r.length));

  always_comb begin
    best_nxt = best_r;
    if (start) begin
      best_nxt = '0;
    end else if (en && take) begin
      best_nxt.found  = 1'b1;
      best_nxt.length = entry.length;
      best_nxt.hop    = entry.hop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else begin
      best_r <= best_nxt;
    end
  end

  assign best = best_r;

endmodule

// ===== src/longest_prefix_route_table.sv =====
// longest prefix route table: insert, lookup and clear over a linear route store
// insert, clear, unused kinds and lookups on an empty table go from the accept straight to
// the result state; a lookup first scans the stored routes, one stored route per cycle through the
// single ram read port and the shared masked-compare unit
// one item at a time: a new item is taken only once the last result is loaded into the output
// register, and out_ready can hold the result back; reset empties the table
module longest_prefix_route_table import lprt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [LEN_W-1:0]  in_prefix_length,
  input  logic [HOP_W-1:0]  in_hop_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [HOP_W-1:0]  out_hop_out,
  output logic [LEN_W-1:0]  out_best_length,
  output logic              out_table_full
);

  // sequencer state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  idx_r;
  kind_t             kind_r;
  logic              full_r;
  logic [ADDR_W-1:0] dest_r;

  // output register
  logic              out_valid_r;
  logic              out_hit_r;
  logic [HOP_W-1:0]  out_hop_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_full_r;

  // control decode
  logic              accept;
  logic              is_full;
  logic              last_idx;
  logic              out_free;
  logic              load_out;
  logic              match_start;
  logic              match_en;
  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  lprt_entry_t       wr_entry;
  lprt_entry_t       rd_entry;
  lprt_best_t        best;

  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == CNT_W'(TABLE_DEPTH));
  // entry under compare is the last stored one
  assign last_idx = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign out_free = !out_valid_r || out_ready;

  assign wr_entry.network = in_address;
  assign wr_entry.length  = sat_len(in_prefix_length);
  assign wr_entry.hop     = in_hop_index;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // empty table lookups skip straight to the result
          if ((kind_t'(in_kind) == KIND_LOOKUP) && (count_r != '0)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (last_idx) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    match_start = 1'b0;
    match_en    = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        match_start = accept;
        ram_we      = accept && (kind_t'(in_kind) == KIND_INSERT) && !is_full;
        // prefetch the first route so the scan runs one per cycle
        ram_re      = accept && (kind_t'(in_kind) == KIND_LOOKUP);
      end
      S_SCAN: begin
        match_en  = 1'b1;
        ram_re    = !last_idx;
        ram_raddr = idx_r + IDX_W'(1);
      end
      S_DONE: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        idx_r <= '0;
        priority case (kind_t'(in_kind))
          KIND_INSERT: if (!is_full) count_r <= count_r + CNT_W'(1);
          KIND_CLEAR:  count_r <= '0;
          default: ;
        endcase
      end else if (state_r == S_SCAN) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_t'(in_kind);
      dest_r <= in_address;
      full_r <= (kind_t'(in_kind) == KIND_INSERT) && is_full;
    end
    if (load_out) begin
      out_hit_r  <= (kind_r == KIND_LOOKUP) && best.found;
      out_hop_r  <= ((kind_r == KIND_LOOKUP) && best.found) ? best.hop : '0;
      out_len_r  <= ((kind_r == KIND_LOOKUP) && best.found) ? best.length : '0;
      out_full_r <= full_r;
    end
  end

  lprt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  lprt_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .start (match_start),
    .en    (match_en),
    .dest  (dest_r),
    .entry (rd_entry),
    .best  (best)
  );

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_hop_out     = out_hop_r;
  assign out_best_length = out_len_r;
  assign out_table_full  = out_full_r;

  // route count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("route count above table depth");

  // a clear empties the table at once
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_CLEAR)) |=> (count_r == '0))
    else $error("clear did not empty the table");

  // the scan only visits stored routes
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CNT_W'(idx_r) < count_r))
    else $error("scan index beyond stored routes");

  // an insert into a full table leaves the count unchanged
  a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_INSERT) && is_full) |=> $stable(count_r))
    else $error("full table grew on insert");

endmodule
